>>> rtl/core/rle_enc_pkg.sv
`timescale 1ns / 1ps
// rle_enc_pkg: shared types and constants of the run-length byte encoder
// used by the front, the back and the top level; depends on nothing

package rle_enc_pkg;

    localparam int WORD_W    = 8;
    localparam int LIT_AW    = 8;
    localparam int LIT_DEPTH = 1 << LIT_AW;
    localparam int GROUP_N   = 4;
    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 2;

    typedef enum logic {
        CMD_LITERAL = 1'b0,
        CMD_REPEAT  = 1'b1
    } t_cmd_kind;

    typedef struct packed {
        logic [WORD_W-1:0] sample;
        logic              stream_last;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] word_a;
        logic [WORD_W-1:0] word_b;
        logic [WORD_W-1:0] word_c;
        logic [WORD_W-1:0] word_d;
        logic [2:0]        word_count;
        logic              item_done;
        logic              stream_done;
    } t_result;

    // arg is the run value for a repeat, the buffer start for a literal
    typedef struct packed {
        t_cmd_kind         kind;
        logic [WORD_W-1:0] count;
        logic [WORD_W-1:0] arg;
        logic              tail;
        logic [WORD_W-1:0] tail_value;
    } t_cmd;

    typedef struct packed {
        t_cmd c0;
        t_cmd c1;
        logic has_c0;
        logic has_c1;
        logic stream_end;
    } t_step_rec;

    typedef struct packed {
        logic              en;
        logic [LIT_AW-1:0] addr;
        logic [WORD_W-1:0] data;
    } t_lit_wr;

endpackage

>>> rtl/core/rle_byte_encoder_core.sv
`timescale 1ns / 1ps
// rle_byte_encoder_core: top level of the run-length byte encoder
// depends on rle_enc_pkg, rle_enc_fifo, rle_enc_front and rle_enc_back

// Samples are taken one per cycle while full is low. The front classifies
// each sample against the held one and, for every sample that closes runs,
// queues one step record (up to two runs) in a four-entry queue; samples of
// literal runs go to a 256-entry buffer and full also rises while that buffer
// has no free entry. The back turns records into code words at one word per
// cycle while the result queue is not full, loading each record before its
// first word; a full literal run holds 127 samples. Words are packed four to
// a result and a two-entry result queue lets the back keep working while the
// oldest result waits for pop.
// The literal buffer needs no clearing after reset.

module rle_byte_encoder_core
    import rle_enc_pkg::*;
#(
    parameter int MAX_REPEAT  = 254,
    parameter int MAX_LITERAL = 127
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    input  t_in_item i_item,
    output logic     full,
    output logic     empty,
    input  logic     pop,
    output t_result  o_result
);

    t_step_rec rec_in;
    t_step_rec rec_out;
    logic      rec_push;
    logic      rec_full;
    logic      rec_pop;
    logic      rec_empty;
    t_lit_wr   lit_wr;
    logic      lit_release;
    t_result   res;
    logic      res_push;
    logic      res_full;

    rle_enc_front #(
        .MAX_REPEAT  (MAX_REPEAT),
        .MAX_LITERAL (MAX_LITERAL)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_item        (i_item),
        .o_full        (full),
        .o_rec_push    (rec_push),
        .o_rec         (rec_in),
        .i_rec_full    (rec_full),
        .o_lit_wr      (lit_wr),
        .i_lit_release (lit_release)
    );

    rle_enc_fifo #(
        .T     (t_step_rec),
        .DEPTH (CMD_DEPTH)
    ) u_rec_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_push),
        .i_data  (rec_in),
        .o_full  (rec_full),
        .i_pop   (rec_pop),
        .o_data  (rec_out),
        .o_empty (rec_empty)
    );

    rle_enc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rec         (rec_out),
        .i_rec_empty   (rec_empty),
        .o_rec_pop     (rec_pop),
        .i_lit_wr      (lit_wr),
        .o_lit_release (lit_release),
        .o_res_push    (res_push),
        .o_res         (res),
        .i_res_full    (res_full)
    );

    rle_enc_fifo #(
        .T     (t_result),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result group pushed into a full result queue");

    a_rec_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rec_push |-> !rec_full)
        else $error("step record pushed into a full record queue");

    a_word_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.word_count != 3'd0 && o_result.word_count <= 3'd4))
        else $error("result group with a word count out of range");

    a_stream_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.stream_done) |-> o_result.item_done)
        else $error("end of stream on a group that does not close its step");

endmodule

>>> rtl/core/rle_enc_fifo.sv
`timescale 1ns / 1ps
// rle_enc_fifo: small register queue for any packed payload type
// standalone, used for the step records and the result groups

module rle_enc_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T                r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic [AW-1:0]   n_wr;
    logic [AW-1:0]   n_rd;
    logic [CW-1:0]   n_count;
    logic            push_ok;
    logic            pop_ok;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (push_ok) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (pop_ok) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + CW'(1);
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> rtl/core/rle_enc_front.sv
`timescale 1ns / 1ps
// rle_enc_front: takes samples, tracks the open runs and emits step records
// depends on rle_enc_pkg; writes literal samples into the back's buffer

module rle_enc_front
    import rle_enc_pkg::*;
#(
    parameter int MAX_REPEAT  = 254,
    parameter int MAX_LITERAL = 127
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_in_item  i_item,
    output logic      o_full,
    output logic      o_rec_push,
    output t_step_rec o_rec,
    input  logic      i_rec_full,
    output t_lit_wr   o_lit_wr,
    input  logic      i_lit_release
);

    localparam int REP_CW = $clog2(MAX_REPEAT + 1);
    localparam int LIT_CW = $clog2(MAX_LITERAL + 1);
    localparam int USED_W = $clog2(LIT_DEPTH + 1);
    localparam logic [REP_CW-1:0] REP_MAX   = REP_CW'(MAX_REPEAT);
    localparam logic [REP_CW-1:0] REP_START = REP_CW'(2);
    localparam logic [LIT_CW-1:0] LIT_MAX   = LIT_CW'(MAX_LITERAL);

    logic [WORD_W-1:0] r_pend_value;
    logic              r_pend_valid;
    logic              r_in_repeat;
    logic [REP_CW-1:0] r_repeat_len;
    logic [LIT_CW-1:0] r_lit_count;
    logic [LIT_AW-1:0] r_lit_start;
    logic [LIT_AW-1:0] r_wr_ptr;
    logic [USED_W-1:0] r_used;

    logic [WORD_W-1:0] n_pend_value;
    logic              n_pend_valid;
    logic              n_in_repeat;
    logic [REP_CW-1:0] n_repeat_len;
    logic [LIT_CW-1:0] n_lit_count;
    logic [LIT_AW-1:0] n_lit_start;
    logic [LIT_AW-1:0] n_wr_ptr;
    logic [USED_W-1:0] n_used;

    logic              accept;
    logic              tail;
    logic [WORD_W-1:0] tail_count;
    t_step_rec         rec;
    t_lit_wr           lit_wr;

    function automatic t_step_rec rec_add(t_step_rec r, t_cmd c);
        t_step_rec o;
        o = r;
        if (!o.has_c0) begin
            o.c0     = c;
            o.has_c0 = 1'b1;
        end else begin
            o.c1     = c;
            o.has_c1 = 1'b1;
        end
        return o;
    endfunction

    function automatic t_cmd rep_cmd(logic [REP_CW-1:0] len, logic [WORD_W-1:0] value);
        t_cmd c;
        c            = '0;
        c.kind       = CMD_REPEAT;
        c.count      = WORD_W'(len);
        c.arg        = value;
        return c;
    endfunction

    function automatic t_cmd lit_cmd(logic [WORD_W-1:0] cnt, logic [LIT_AW-1:0] start,
                                     logic tl, logic [WORD_W-1:0] tv);
        t_cmd c;
        c            = '0;
        c.kind       = CMD_LITERAL;
        c.count      = cnt;
        c.arg        = WORD_W'(start);
        c.tail       = tl;
        c.tail_value = tv;
        return c;
    endfunction

    assign o_full = i_rec_full || (r_used >= USED_W'(LIT_DEPTH));
    assign accept = i_push && !o_full;

    always_comb begin
        n_pend_value = r_pend_value;
        n_pend_valid = r_pend_valid;
        n_in_repeat  = r_in_repeat;
        n_repeat_len = r_repeat_len;
        n_lit_count  = r_lit_count;
        n_lit_start  = r_lit_start;
        n_wr_ptr     = r_wr_ptr;
        rec          = '0;
        lit_wr       = '0;
        tail         = 1'b0;
        tail_count   = '0;
        if (accept) begin
            if (n_in_repeat) begin
                if (i_item.sample == n_pend_value && n_repeat_len < REP_MAX) begin
                    n_repeat_len = n_repeat_len + REP_CW'(1);
                    if (n_repeat_len >= REP_MAX) begin
                        rec          = rec_add(rec, rep_cmd(n_repeat_len, n_pend_value));
                        n_in_repeat  = 1'b0;
                        n_pend_valid = 1'b0;
                        n_repeat_len = '0;
                    end
                end else begin
                    rec          = rec_add(rec, rep_cmd(n_repeat_len, n_pend_value));
                    n_in_repeat  = 1'b0;
                    n_repeat_len = '0;
                    n_pend_value = i_item.sample;
                    n_pend_valid = 1'b1;
                end
            end else if (n_pend_valid) begin
                if (i_item.sample == n_pend_value) begin
                    if (n_lit_count != '0) begin
                        rec = rec_add(rec, lit_cmd(WORD_W'(n_lit_count), n_lit_start,
                                                   1'b0, '0));
                    end
                    n_lit_count  = '0;
                    n_lit_start  = n_wr_ptr;
                    n_in_repeat  = 1'b1;
                    n_pend_valid = 1'b0;
                    n_repeat_len = REP_START;
                    if (REP_START >= REP_MAX) begin
                        rec          = rec_add(rec, rep_cmd(n_repeat_len, n_pend_value));
                        n_in_repeat  = 1'b0;
                        n_repeat_len = '0;
                    end
                end else begin
                    lit_wr.en   = 1'b1;
                    lit_wr.addr = n_wr_ptr;
                    lit_wr.data = n_pend_value;
                    n_wr_ptr    = n_wr_ptr + LIT_AW'(1);
                    n_lit_count = n_lit_count + LIT_CW'(1);
                    if (n_lit_count >= LIT_MAX) begin
                        rec = rec_add(rec, lit_cmd(WORD_W'(n_lit_count), n_lit_start,
                                                   1'b0, '0));
                        n_lit_count = '0;
                        n_lit_start = n_wr_ptr;
                    end
                    n_pend_value = i_item.sample;
                    n_pend_valid = 1'b1;
                end
            end else begin
                n_pend_value = i_item.sample;
                n_pend_valid = 1'b1;
            end
            if (i_item.stream_last) begin
                if (n_in_repeat) begin
                    rec          = rec_add(rec, rep_cmd(n_repeat_len, n_pend_value));
                    n_pend_valid = 1'b0;
                end
                // a held sample closes the literal run straight from the record
                tail       = n_pend_valid;
                tail_count = WORD_W'(n_lit_count) + WORD_W'(tail);
                if (tail_count != '0) begin
                    rec = rec_add(rec, lit_cmd(tail_count, n_lit_start, tail, n_pend_value));
                end
                n_pend_value = '0;
                n_pend_valid = 1'b0;
                n_in_repeat  = 1'b0;
                n_repeat_len = '0;
                n_lit_count  = '0;
                n_lit_start  = n_wr_ptr;
            end
            rec.stream_end = i_item.stream_last;
        end
        n_used = r_used + USED_W'(lit_wr.en) - USED_W'(i_lit_release);
    end

    assign o_rec_push = accept && rec.has_c0;
    assign o_rec      = rec;
    assign o_lit_wr   = lit_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_value <= '0;
            r_pend_valid <= 1'b0;
            r_in_repeat  <= 1'b0;
            r_repeat_len <= '0;
            r_lit_count  <= '0;
            r_lit_start  <= '0;
            r_wr_ptr     <= '0;
            r_used       <= '0;
        end else begin
            r_pend_value <= n_pend_value;
            r_pend_valid <= n_pend_valid;
            r_in_repeat  <= n_in_repeat;
            r_repeat_len <= n_repeat_len;
            r_lit_count  <= n_lit_count;
            r_lit_start  <= n_lit_start;
            r_wr_ptr     <= n_wr_ptr;
            r_used       <= n_used;
        end
    end

endmodule

>>> rtl/core/rle_enc_back.sv
`timescale 1ns / 1ps
// rle_enc_back: literal buffer, code word sequencer and four-word packer
// depends on rle_enc_pkg; fed by step records from the front

module rle_enc_back
    import rle_enc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_step_rec i_rec,
    input  logic      i_rec_empty,
    output logic      o_rec_pop,
    input  t_lit_wr   i_lit_wr,
    output logic      o_lit_release,
    output logic      o_res_push,
    output t_result   o_res,
    input  logic      i_res_full
);

    localparam int JW = WORD_W + 1;
    localparam int GW = $clog2(GROUP_N);

    typedef struct packed {
        logic              is_mem;
        logic [WORD_W-1:0] imm;
        logic              item_end;
        logic              stream_end;
    } t_token;

    logic [WORD_W-1:0]              r_lit_mem [LIT_DEPTH];
    logic [WORD_W-1:0]              r_rd_data;
    logic                           r_busy;
    t_step_rec                      r_rec;
    logic                           r_sel;
    logic [JW-1:0]                  r_j;
    logic                           r_b_valid;
    t_token                         r_b_tok;
    logic [GROUP_N-1:0][WORD_W-1:0] r_words;
    logic [GW-1:0]                  r_gcnt;

    t_cmd                           cur;
    logic [JW-1:0]                  cnt_ext;
    logic [JW-1:0]                  len;
    logic [JW-1:0]                  k_ext;
    logic [WORD_W-1:0]              k;
    logic                           last_word;
    logic                           item_last;
    logic [LIT_AW-1:0]              rd_addr;
    t_token                         tok;
    logic                           adv;
    logic                           issue;
    logic [WORD_W-1:0]              word;
    logic [GROUP_N-1:0][WORD_W-1:0] grp;
    logic                           emit;

    assign cur       = r_sel ? r_rec.c1 : r_rec.c0;
    assign cnt_ext   = JW'(cur.count);
    assign len       = (cur.kind == CMD_REPEAT) ? JW'(2) :
                       cnt_ext + JW'(2) + JW'(cur.count[0]);
    assign last_word = (r_j == len - JW'(1));
    assign item_last = last_word && (r_sel || !r_rec.has_c1);
    assign k_ext     = r_j - JW'(2);
    assign k         = k_ext[WORD_W-1:0];
    assign adv       = !i_res_full;
    assign issue     = r_busy && adv;

    // word order of a literal run: zero, count, samples, pad when odd
    always_comb begin
        tok            = '0;
        tok.item_end   = item_last;
        tok.stream_end = r_rec.stream_end;
        rd_addr        = cur.arg[LIT_AW-1:0] + k[LIT_AW-1:0];
        case (cur.kind)
            CMD_REPEAT: begin
                tok.imm = (r_j == '0) ? cur.count : cur.arg;
            end
            CMD_LITERAL: begin
                if (r_j == '0) begin
                    tok.imm = '0;
                end else if (r_j == JW'(1)) begin
                    tok.imm = cur.count;
                end else if (r_j < cnt_ext + JW'(2)) begin
                    if (cur.tail && k == cur.count - WORD_W'(1)) begin
                        tok.imm = cur.tail_value;
                    end else begin
                        tok.is_mem = 1'b1;
                    end
                end else begin
                    tok.imm = '0;
                end
            end
            default: begin
                tok.imm = '0;
            end
        endcase
    end

    assign o_rec_pop     = !r_busy && !i_rec_empty;
    assign o_lit_release = issue && tok.is_mem;

    always_comb begin
        word         = r_b_tok.is_mem ? r_rd_data : r_b_tok.imm;
        grp          = r_words;
        grp[r_gcnt]  = word;
        emit         = adv && r_b_valid &&
                       (r_gcnt == GW'(GROUP_N - 1) || r_b_tok.item_end);
        o_res             = '0;
        o_res.word_a      = grp[0];
        o_res.word_b      = grp[1];
        o_res.word_c      = grp[2];
        o_res.word_d      = grp[3];
        o_res.word_count  = 3'(r_gcnt) + 3'd1;
        o_res.item_done   = r_b_tok.item_end;
        o_res.stream_done = r_b_tok.item_end && r_b_tok.stream_end;
    end

    assign o_res_push = emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_sel     <= 1'b0;
            r_j       <= '0;
            r_b_valid <= 1'b0;
            r_gcnt    <= '0;
            r_words   <= '0;
        end else begin
            if (o_rec_pop) begin
                r_busy <= 1'b1;
                r_sel  <= 1'b0;
                r_j    <= '0;
            end else if (issue) begin
                if (last_word) begin
                    if (item_last) begin
                        r_busy <= 1'b0;
                    end else begin
                        r_sel <= 1'b1;
                        r_j   <= '0;
                    end
                end else begin
                    r_j <= r_j + JW'(1);
                end
            end
            if (adv) begin
                r_b_valid <= issue;
            end
            if (adv && r_b_valid) begin
                if (emit) begin
                    r_words <= '0;
                    r_gcnt  <= '0;
                end else begin
                    r_words[r_gcnt] <= word;
                    r_gcnt          <= r_gcnt + GW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rec_pop) begin
            r_rec <= i_rec;
        end
        if (adv) begin
            r_b_tok <= tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_lit_wr.en) begin
            r_lit_mem[i_lit_wr.addr] <= i_lit_wr.data;
        end
        if (issue && tok.is_mem) begin
            r_rd_data <= r_lit_mem[rd_addr];
        end
    end

endmodule
